### design/phase_shifted_pwm_generator_core_macros.svh
// Assertion macros for the phase-shifted PWM core.
// Expects clk and rst in the scope of use; no other dependencies.
`ifndef PHASE_SHIFTED_PWM_GENERATOR_CORE_MACROS_SVH
`define PHASE_SHIFTED_PWM_GENERATOR_CORE_MACROS_SVH

// Same-cycle implication, held off during reset.
`define PSP_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off during reset.
`define PSP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/psp_pkg.sv
// Shared types, constants and functions of the phase-shifted PWM core.
// No dependencies.
package psp_pkg;

  localparam int DEFAULT_BANK_COUNT = 3;
  localparam int DEFAULT_COUNT_BITS = 16;

  localparam int CFG_INDEX_BITS = 5;
  localparam int CFG_DATA_BITS  = 32;
  localparam int FIELD_BITS     = 16;
  localparam int PRESCALE_BITS  = 10;
  localparam int DIV_SEL_BITS   = 3;

  localparam int REG_PERIOD_TOP    = 0;
  localparam int REG_DIVIDE_SELECT = 1;
  localparam int REG_COMPARE_BASE  = 2;

  typedef enum logic [DIV_SEL_BITS-1:0] {
    DIV_BY_1    = 3'd0,
    DIV_BY_8    = 3'd1,
    DIV_BY_64   = 3'd2,
    DIV_BY_256  = 3'd3,
    DIV_BY_1024 = 3'd4
  } div_sel_t;

  typedef struct packed {
    logic advance;
    logic run;
    logic restart;
  } psp_step_t;

  // terminal prescaler count; codes above four behave as divide by 1024
  function automatic logic [PRESCALE_BITS-1:0] prescale_term(
    input logic [DIV_SEL_BITS-1:0] sel
  );
    logic [PRESCALE_BITS-1:0] term;
    unique case (sel)
      DIV_BY_1:   term = PRESCALE_BITS'(0);
      DIV_BY_8:   term = PRESCALE_BITS'(7);
      DIV_BY_64:  term = PRESCALE_BITS'(63);
      DIV_BY_256: term = PRESCALE_BITS'(255);
      default:    term = PRESCALE_BITS'(1023);
    endcase
    return term;
  endfunction

endpackage

### design/psp_ifs.sv
// Handshake channels of the phase-shifted PWM core: command, result, config.
// Depends on psp_pkg.
interface psp_cmd_if;
  logic valid;
  logic ready;
  logic run;
  logic restart;

  modport source (output valid, output run, output restart, input ready);
  modport sink (input valid, input run, input restart, output ready);
endinterface

interface psp_result_if import psp_pkg::*; #(
  parameter int BANK_COUNT = DEFAULT_BANK_COUNT
);
  logic                    valid;
  logic                    ready;
  logic [2*BANK_COUNT-1:0] pin_levels;
  logic [BANK_COUNT-1:0]   bank_wrapped;

  modport source (output valid, output pin_levels, output bank_wrapped, input ready);
  modport sink (input valid, input pin_levels, input bank_wrapped, output ready);
endinterface

interface psp_cfg_if import psp_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic [CFG_INDEX_BITS-1:0] index;
  logic [CFG_DATA_BITS-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### design/psp_cfg_regs.sv
// Configuration register file: top, prescaler select, compares, offsets.
// Depends on psp_pkg and psp_cfg_if.
module psp_cfg_regs import psp_pkg::*; #(
  parameter int BANK_COUNT = DEFAULT_BANK_COUNT,
  parameter int COUNT_BITS = DEFAULT_COUNT_BITS
) (
  input  logic                     clk,
  input  logic                     rst,
  psp_cfg_if.sink                  cfg,
  output logic [COUNT_BITS-1:0]    top,
  output logic [DIV_SEL_BITS-1:0]  div_sel,
  output logic [CFG_DATA_BITS-1:0] compares [BANK_COUNT],
  output logic [COUNT_BITS-1:0]    offsets [BANK_COUNT]
);

  localparam int RegOffsetBase = REG_COMPARE_BASE + BANK_COUNT;

  logic [CFG_DATA_BITS-1:0] field_ext;
  logic                     wr;

  assign cfg.ready = 1'b1;
  assign wr        = cfg.valid && cfg.ready;
  // 16-bit fields masked again to the counter width
  assign field_ext = {{(CFG_DATA_BITS-FIELD_BITS){1'b0}}, cfg.data[FIELD_BITS-1:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      top     <= '0;
      div_sel <= '0;
      for (int b = 0; b < BANK_COUNT; b++) begin
        compares[b] <= '0;
        offsets[b]  <= '0;
      end
    end else if (wr) begin
      if (cfg.index == CFG_INDEX_BITS'(REG_PERIOD_TOP)) begin
        top <= field_ext[COUNT_BITS-1:0];
      end
      if (cfg.index == CFG_INDEX_BITS'(REG_DIVIDE_SELECT)) begin
        div_sel <= cfg.data[DIV_SEL_BITS-1:0];
      end
      for (int b = 0; b < BANK_COUNT; b++) begin
        if (cfg.index == CFG_INDEX_BITS'(REG_COMPARE_BASE + b)) begin
          compares[b] <= cfg.data;
        end
        if (cfg.index == CFG_INDEX_BITS'(RegOffsetBase + b)) begin
          offsets[b] <= field_ext[COUNT_BITS-1:0];
        end
      end
    end
  end

endmodule

### design/psp_prescaler.sv
// Shared clock prescaler: gives one count pulse every 1..1024 running ticks.
// Depends on psp_pkg.
module psp_prescaler import psp_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  psp_step_t               step,
  input  logic [DIV_SEL_BITS-1:0] div_sel,
  output logic                    pulse
);

  logic [PRESCALE_BITS-1:0] prescale_count;
  logic [PRESCALE_BITS-1:0] prescale_count_next;

  // a count left beyond the terminal value by a divider change pulses at once
  assign pulse = prescale_count >= prescale_term(div_sel);

  always_comb begin
    prescale_count_next = prescale_count;
    if (step.restart) begin
      prescale_count_next = '0;
    end else if (step.run) begin
      prescale_count_next = pulse ? '0 : prescale_count + PRESCALE_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prescale_count <= '0;
    end else if (step.advance) begin
      prescale_count <= prescale_count_next;
    end
  end

endmodule

### design/psp_bank.sv
// One PWM bank: up counter with phase-offset load and two compare outputs.
// Depends on psp_pkg.
module psp_bank import psp_pkg::*; #(
  parameter int COUNT_BITS = DEFAULT_COUNT_BITS
) (
  input  logic                     clk,
  input  logic                     rst,
  input  psp_step_t                step,
  input  logic                     pulse,
  input  logic [COUNT_BITS-1:0]    top,
  input  logic [CFG_DATA_BITS-1:0] compares,
  input  logic [COUNT_BITS-1:0]    offset,
  output logic [1:0]               pins,
  output logic                     wrapped
);

  logic [COUNT_BITS-1:0]    bank_count;
  logic [COUNT_BITS-1:0]    bank_count_next;
  logic [CFG_DATA_BITS-1:0] count_ext;
  logic [CFG_DATA_BITS-1:0] cmp_a;
  logic [CFG_DATA_BITS-1:0] cmp_b;

  assign wrapped = !step.restart && step.run && pulse && (bank_count >= top);

  always_comb begin
    bank_count_next = bank_count;
    if (step.restart) begin
      bank_count_next = (offset > top) ? top : offset;
    end else if (step.run && pulse) begin
      bank_count_next = wrapped ? '0 : bank_count + COUNT_BITS'(1);
    end
  end

  assign count_ext = CFG_DATA_BITS'(bank_count_next);
  assign cmp_a     = CFG_DATA_BITS'(compares[FIELD_BITS-1:0]);
  assign cmp_b     = CFG_DATA_BITS'(compares[2*FIELD_BITS-1:FIELD_BITS]);
  assign pins      = step.run ? {count_ext <= cmp_b, count_ext <= cmp_a} : 2'b00;

  always_ff @(posedge clk) begin
    if (rst) begin
      bank_count <= '0;
    end else if (step.advance) begin
      bank_count <= bank_count_next;
    end
  end

endmodule

### design/phase_shifted_pwm_generator_core.sv
// Top level of the phase-shifted PWM core: input register, banks, result register.
// Depends on psp_pkg, psp_ifs, psp_cfg_regs, psp_prescaler, psp_bank and the macros.
//
// Usage:
//   cmd    : one word per clock tick of the timer, carrying run and restart.
//   result : one word per cmd word, carrying pin_levels (bit 2b channel A,
//            bit 2b+1 channel B of bank b) and bank_wrapped (one bit per bank).
//   cfg    : register writes by index (0 top, 1 divide select, then the bank
//            compares, then the bank offsets); always ready, indexes past the
//            list are dropped. Write only while no word is in flight.
// Path: a cmd word accepted passes the input register, then the result register,
//   which gives its result word.
// Throughput: one word per cycle while result.ready is high; the prescaler, bank
//   counters and compares settle in the single pass between the two registers.
// Reset (rst, synchronous): registers, prescaler and counters clear to zero,
//   both pipeline stages empty.
// Stall: while result.ready is low the result word holds; the input register
//   still takes one more word, then cmd.ready drops until the result moves.
`include "phase_shifted_pwm_generator_core_macros.svh"

module phase_shifted_pwm_generator_core import psp_pkg::*; #(
  parameter int BANK_COUNT = DEFAULT_BANK_COUNT,
  parameter int COUNT_BITS = DEFAULT_COUNT_BITS
) (
  input  logic          clk,
  input  logic          rst,
  psp_cmd_if.sink       cmd,
  psp_result_if.source  result,
  psp_cfg_if.sink       cfg
);

  logic                     stage_valid;
  logic                     stage_run;
  logic                     stage_restart;
  logic                     advance;
  psp_step_t                step;
  logic                     pulse;

  logic [COUNT_BITS-1:0]    top;
  logic [DIV_SEL_BITS-1:0]  div_sel;
  logic [CFG_DATA_BITS-1:0] compares [BANK_COUNT];
  logic [COUNT_BITS-1:0]    offsets [BANK_COUNT];

  logic [2*BANK_COUNT-1:0]  pins_next;
  logic [BANK_COUNT-1:0]    wrapped_next;

  assign advance   = stage_valid && (!result.valid || result.ready);
  assign cmd.ready = !stage_valid || advance;

  assign step.advance = advance;
  assign step.run     = stage_run;
  assign step.restart = stage_restart;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (cmd.valid && cmd.ready) begin
      stage_valid <= 1'b1;
    end else if (advance) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      stage_run     <= cmd.run;
      stage_restart <= cmd.restart;
    end
  end

  psp_cfg_regs #(
    .BANK_COUNT (BANK_COUNT),
    .COUNT_BITS (COUNT_BITS)
  ) u_cfg_regs (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .top      (top),
    .div_sel  (div_sel),
    .compares (compares),
    .offsets  (offsets)
  );

  psp_prescaler u_prescaler (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .div_sel (div_sel),
    .pulse   (pulse)
  );

  for (genvar b = 0; b < BANK_COUNT; b++) begin : g_bank
    psp_bank #(
      .COUNT_BITS (COUNT_BITS)
    ) u_bank (
      .clk      (clk),
      .rst      (rst),
      .step     (step),
      .pulse    (pulse),
      .top      (top),
      .compares (compares[b]),
      .offset   (offsets[b]),
      .pins     (pins_next[2*b +: 2]),
      .wrapped  (wrapped_next[b])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (advance) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result.pin_levels   <= pins_next;
      result.bank_wrapped <= wrapped_next;
    end
  end

  `PSP_ASSERT_NEXT(a_stopped_pins_low, advance && !stage_run,
    result.pin_levels == '0, "pins not low for a stopped tick")
  `PSP_ASSERT_NEXT(a_restart_no_wrap, advance && stage_restart,
    result.bank_wrapped == '0, "wrap flagged on a restart tick")
  `PSP_ASSERT_NEXT(a_zero_top_wraps,
    advance && stage_run && !stage_restart && pulse && (top == '0),
    result.bank_wrapped == '1, "zero top pulse did not wrap every bank")
  `PSP_ASSERT_IMPLY(a_no_word_lost, result.valid && !result.ready && stage_valid,
    !cmd.ready, "input taken while both stages are full")

endmodule
